// ===== hw/rtl/hsm_pkg.sv =====
// ----------------------------------------------------------------------------
// hsm_pkg
// Shared types, constants and register map for the handheld sound mixer.
// ----------------------------------------------------------------------------
package hsm_pkg;

  localparam int SAMPLE_CYCLES = 512;
  localparam int FIFO_DEPTH    = 32;
  localparam int REG_WORDS     = 128;
  localparam int MAX_OUT       = 4;

  localparam int REG_AW  = 7;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);
  localparam int ACC_W   = (SAMPLE_CYCLES > 1) ? $clog2(SAMPLE_CYCLES) : 1;
  // accumulator plus the widest cycles field
  localparam int TOT_W   = $clog2(SAMPLE_CYCLES + 4096);
  localparam int DIV_W   = 14;

  // operation codes
  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_WRITE  = 3'd1;
  localparam logic [2:0] MODE_READ   = 3'd2;
  localparam logic [2:0] MODE_PUSH_A = 3'd3;
  localparam logic [2:0] MODE_PUSH_B = 3'd4;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // shadow copies of the registers a tick needs
  localparam int SH_MIX   = 0;
  localparam int SH_SQ1C  = 1;
  localparam int SH_SQ1F  = 2;
  localparam int SH_SQ2C  = 3;
  localparam int SH_SQ2F  = 4;
  localparam int SH_WVC   = 5;
  localparam int SH_WVF   = 6;
  localparam int SH_NZC   = 7;
  localparam int SH_NZF   = 8;
  localparam int SH_ROUTE = 9;
  localparam int NUM_SHADOW = 10;

  localparam logic [REG_AW-1:0] RA_SQ1C  = 7'h31;
  localparam logic [REG_AW-1:0] RA_SQ1F  = 7'h32;
  localparam logic [REG_AW-1:0] RA_SQ2C  = 7'h34;
  localparam logic [REG_AW-1:0] RA_SQ2F  = 7'h36;
  localparam logic [REG_AW-1:0] RA_WVC   = 7'h38;
  localparam logic [REG_AW-1:0] RA_WVF   = 7'h3A;
  localparam logic [REG_AW-1:0] RA_NZC   = 7'h3C;
  localparam logic [REG_AW-1:0] RA_NZF   = 7'h3E;
  localparam logic [REG_AW-1:0] RA_MIX   = 7'h40;
  localparam logic [REG_AW-1:0] RA_ROUTE = 7'h41;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  address;
    logic [31:0] write_data;
    logic [11:0] cycles;
  } hsm_cmd_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [15:0]        read_data;
    logic               last;
  } hsm_res_t;

  // shadow slot to register word
  function automatic logic [REG_AW-1:0] hsm_reg_addr(input logic [3:0] idx);
    logic [REG_AW-1:0] a;
    unique case (idx)
      4'd0:    a = RA_MIX;
      4'd1:    a = RA_SQ1C;
      4'd2:    a = RA_SQ1F;
      4'd3:    a = RA_SQ2C;
      4'd4:    a = RA_SQ2F;
      4'd5:    a = RA_WVC;
      4'd6:    a = RA_WVF;
      4'd7:    a = RA_NZC;
      4'd8:    a = RA_NZF;
      default: a = RA_ROUTE;
    endcase
    return a;
  endfunction

endpackage

// ===== hw/rtl/hsm_ram.sv =====
// ----------------------------------------------------------------------------
// hsm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/hsm_mod.sv =====
// ----------------------------------------------------------------------------
// hsm_mod
// Iterative restoring modulo unit, one remainder bit per cycle.
// ----------------------------------------------------------------------------
module hsm_mod (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [hsm_pkg::DIV_W-1:0] dividend,
  input  logic [hsm_pkg::DIV_W-1:0] divisor,
  output logic                     done,
  output logic [hsm_pkg::DIV_W-1:0] rem
);
  import hsm_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] shreg;
  logic [DIV_W-1:0] dvs;
  logic [DIV_W:0]   trial;

  assign trial = {rem, shreg[DIV_W-1]};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      shreg <= dividend;
      dvs   <= divisor;
    end else if (busy) begin
      shreg <= shreg << 1;
      if (trial >= {1'b0, dvs}) begin
        rem <= DIV_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[DIV_W-1:0];
      end
    end
  end

endmodule

// ===== hw/rtl/handheld_sound_mixer.sv =====
// ----------------------------------------------------------------------------
// handheld_sound_mixer
// Sound unit: register file, two sample FIFOs, tone/noise synthesis and mix.
// ----------------------------------------------------------------------------
// One command beat is taken at a time. Register writes and unused modes are
// done in the accept cycle, a read waits on the registered register RAM read,
// and a FIFO push, after the accept cycle, writes one byte per cycle through
// the FIFO RAM write port. A tick first copies ten registers out of the
// register RAM, then builds each sample with up to three passes (start,
// 14 iterations, done) through the shared modulo unit that wraps the two
// square phases and the wave phase. A sample beat waits while the result
// register is still held by the sink.
module handheld_sound_mixer (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  hsm_pkg::hsm_cmd_t cmd,
  output logic              res_valid,
  input  logic              res_ready,
  output hsm_pkg::hsm_res_t res
);
  import hsm_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_RD_EMIT = 4'd1;
  localparam logic [3:0] ST_PUSH    = 4'd2;
  localparam logic [3:0] ST_LOAD    = 4'd3;
  localparam logic [3:0] ST_START   = 4'd4;
  localparam logic [3:0] ST_SQ1     = 4'd5;
  localparam logic [3:0] ST_SQ1_W   = 4'd6;
  localparam logic [3:0] ST_SQ2     = 4'd7;
  localparam logic [3:0] ST_SQ2_W   = 4'd8;
  localparam logic [3:0] ST_WAVE    = 4'd9;
  localparam logic [3:0] ST_WAVE_W  = 4'd10;
  localparam logic [3:0] ST_NOISE   = 4'd11;
  localparam logic [3:0] ST_FIFO    = 4'd12;
  localparam logic [3:0] ST_MIX     = 4'd13;
  localparam logic [3:0] ST_EMIT    = 4'd14;

  logic [3:0] state;

  // architectural state outside the RAMs
  logic [ACC_W-1:0]   accum;
  logic [12:0]        ph1, ph2;
  logic [11:0]        phw;
  logic [14:0]        lfsr;
  logic [21:0]        nz_cnt;
  logic [FIFO_AW-1:0] head_a, head_b;
  logic [FIFO_CW-1:0] fill_a, fill_b;
  logic [REG_WORDS-1:0] reg_valid;

  // working registers
  logic [15:0]        shadow [NUM_SHADOW];
  logic [3:0]         ld_cnt;
  logic [1:0]         smp_k, smp_last;
  logic [1:0]         push_cnt;
  logic               push_b;
  logic [31:0]        push_data;
  logic signed [12:0] s1, s2, wv, nz;
  logic signed [17:0] lsc, rsc;
  logic signed [15:0] smp_l, smp_r;
  logic               pop_a, pop_b;

  // ---------------------------------------------------------------- helpers
  function automatic logic [11:0] tone_p(input logic [15:0] frq);
    return 12'(13'd2048 - {2'b0, frq[10:0]});
  endfunction

  function automatic logic signed [12:0] chan_vol(input logic [15:0] ctl);
    return $signed({1'b0, ctl[15:12], 8'b0});
  endfunction

  function automatic logic [DIV_W-1:0] sq_thr(input logic [15:0] ctl, input logic [11:0] p);
    logic [DIV_W-1:0] t;
    case (ctl[7:6])
      2'd0:    t = DIV_W'(p >> 1);
      2'd1:    t = DIV_W'(p);
      2'd2:    t = DIV_W'({p, 1'b0});
      default: t = DIV_W'({p, 1'b0}) + DIV_W'(p);
    endcase
    return t;
  endfunction

  function automatic logic [FIFO_AW-1:0] fifo_wrap(input logic [FIFO_CW:0] v);
    logic [FIFO_CW:0] w;
    w = (v >= (FIFO_CW+1)'(FIFO_DEPTH)) ? v - (FIFO_CW+1)'(FIFO_DEPTH) : v;
    return w[FIFO_AW-1:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] o;
    if (v > 20'sd32767) o = 16'sh7FFF;
    else if (v < -20'sd32768) o = 16'sh8000;
    else o = v[15:0];
    return o;
  endfunction

  // ----------------------------------------------------------- output stage
  logic     slot_free;
  logic     load_out;
  hsm_res_t out_next;

  assign slot_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res <= out_next;
    end
  end

  // ---------------------------------------------------------- register RAM
  logic              cmd_fire;
  logic              rf_we, rf_re;
  logic [REG_AW-1:0] rf_waddr, rf_raddr;
  logic [15:0]       rf_rdata;
  logic              rf_vq;
  logic [15:0]       reg_word;
  logic [REG_AW-1:0] cmd_word;

  assign cmd_ready = (state == ST_IDLE);
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign cmd_word  = cmd.address[7:1];

  assign rf_we    = cmd_fire && (cmd.mode == MODE_WRITE) &&
                    ({1'b0, cmd_word} < 8'(REG_WORDS));
  assign rf_waddr = cmd_word;
  assign rf_re    = (cmd_fire && (cmd.mode == MODE_READ)) ||
                    ((state == ST_LOAD) && (ld_cnt < 4'(NUM_SHADOW)));
  assign rf_raddr = (state == ST_LOAD) ? hsm_reg_addr(ld_cnt) : cmd_word;
  assign reg_word = rf_vq ? rf_rdata : 16'd0;

  hsm_ram #(.WIDTH(16), .DEPTH(1 << REG_AW)) u_regs (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (cmd.write_data[15:0]),
    .re    (rf_re),
    .raddr (rf_raddr),
    .rdata (rf_rdata)
  );

  // valid bits stand in for the all-zero reset of the register RAM
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_valid <= '0;
    end else if (rf_we) begin
      reg_valid[rf_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rf_re) begin
      rf_vq <= ({1'b0, rf_raddr} < 8'(REG_WORDS)) && reg_valid[rf_raddr];
    end
  end

  // -------------------------------------------------------------- FIFO RAMs
  logic               fa_we, fb_we, f_re;
  logic [FIFO_AW-1:0] fa_waddr, fb_waddr;
  logic [7:0]         push_byte;
  logic [7:0]         fa_rdata, fb_rdata;

  assign push_byte = push_data[8*push_cnt +: 8];
  assign fa_we     = (state == ST_PUSH) && !push_b && (fill_a < FIFO_CW'(FIFO_DEPTH));
  assign fb_we     = (state == ST_PUSH) &&  push_b && (fill_b < FIFO_CW'(FIFO_DEPTH));
  assign fa_waddr  = fifo_wrap((FIFO_CW+1)'(head_a) + (FIFO_CW+1)'(fill_a));
  assign fb_waddr  = fifo_wrap((FIFO_CW+1)'(head_b) + (FIFO_CW+1)'(fill_b));
  assign f_re      = (state == ST_FIFO);

  hsm_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_fifo_a (
    .clk   (clk),
    .we    (fa_we),
    .waddr (fa_waddr),
    .wdata (push_byte),
    .re    (f_re),
    .raddr (head_a),
    .rdata (fa_rdata)
  );

  hsm_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_fifo_b (
    .clk   (clk),
    .we    (fb_we),
    .waddr (fb_waddr),
    .wdata (push_byte),
    .re    (f_re),
    .raddr (head_b),
    .rdata (fb_rdata)
  );

  // ---------------------------------------------------------- modulo unit
  logic             div_start, div_done;
  logic [DIV_W-1:0] div_a, div_d, div_rem;

  always_comb begin
    div_start = 1'b0;
    div_a     = DIV_W'({1'b0, ph1}) + 1'b1;
    div_d     = DIV_W'({tone_p(shadow[SH_SQ1F]), 2'b0});
    case (state)
      ST_SQ1: begin
        div_start = shadow[SH_SQ1F][15];
      end
      ST_SQ2: begin
        div_start = shadow[SH_SQ2F][15];
        div_a     = DIV_W'({1'b0, ph2}) + 1'b1;
        div_d     = DIV_W'({tone_p(shadow[SH_SQ2F]), 2'b0});
      end
      ST_WAVE: begin
        div_start = shadow[SH_WVC][7] && shadow[SH_WVF][15];
        div_a     = DIV_W'({2'b0, phw}) + 1'b1;
        div_d     = DIV_W'({tone_p(shadow[SH_WVF]), 1'b0});
      end
      default: ;
    endcase
  end

  hsm_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_d),
    .done     (div_done),
    .rem      (div_rem)
  );

  // ----------------------------------------------------- tick bookkeeping
  logic [TOT_W-1:0] tick_total, tick_due;

  assign tick_total = TOT_W'(accum) + TOT_W'(cmd.cycles);
  assign tick_due   = TOT_W'(tick_total / SAMPLE_CYCLES);

  // --------------------------------------------------------- noise step
  logic [6:0]  nz_base;
  logic [21:0] nz_period;
  logic [22:0] nz_inc;
  logic        nz_fb;
  logic [14:0] lfsr_step;

  always_comb begin
    nz_base   = (shadow[SH_NZC][2:0] == 3'd0) ? 7'd8 : {shadow[SH_NZC][2:0], 4'b0};
    nz_period = 22'(nz_base) << shadow[SH_NZC][7:4];
    nz_inc    = {1'b0, nz_cnt} + 1'b1;
    nz_fb     = lfsr[0] ^ lfsr[1];
    lfsr_step = {nz_fb, lfsr[14:1]};
    if (shadow[SH_NZC][3]) begin
      lfsr_step[6] = nz_fb;
    end
  end

  // ----------------------------------------------------------- mix math
  logic [15:0]        mixw;
  logic signed [15:0] lsum, rsum;
  logic signed [4:0]  lk, rk;
  logic signed [20:0] lprod, rprod, ladj, radj;
  logic signed [15:0] fa_v, fb_v;
  logic signed [19:0] lfin, rfin;

  always_comb begin
    mixw = shadow[SH_MIX];
    lsum = (mixw[4] ? 16'(s1) : 16'sd0) + (mixw[5] ? 16'(s2) : 16'sd0) +
           (mixw[6] ? 16'(wv) : 16'sd0) + (mixw[7] ? 16'(nz) : 16'sd0);
    rsum = (mixw[0] ? 16'(s1) : 16'sd0) + (mixw[1] ? 16'(s2) : 16'sd0) +
           (mixw[2] ? 16'(wv) : 16'sd0) + (mixw[3] ? 16'(nz) : 16'sd0);
    lk    = $signed({1'b0, 4'({1'b0, mixw[6:4]} + 4'd1)});
    rk    = $signed({1'b0, 4'({1'b0, mixw[2:0]} + 4'd1)});
    lprod = 21'(lsum) * 21'(lk);
    rprod = 21'(rsum) * 21'(rk);
    // divide by eight, rounding toward zero
    ladj  = lprod + ((lprod < 0) ? 21'sd7 : 21'sd0);
    radj  = rprod + ((rprod < 0) ? 21'sd7 : 21'sd0);
    fa_v  = pop_a ? $signed({fa_rdata, 8'b0}) : 16'sd0;
    fb_v  = pop_b ? $signed({fb_rdata, 8'b0}) : 16'sd0;
    lfin  = 20'(lsc) + (shadow[SH_ROUTE][9]  ? 20'(fa_v) : 20'sd0) +
                       (shadow[SH_ROUTE][13] ? 20'(fb_v) : 20'sd0);
    rfin  = 20'(rsc) + (shadow[SH_ROUTE][8]  ? 20'(fa_v) : 20'sd0) +
                       (shadow[SH_ROUTE][12] ? 20'(fb_v) : 20'sd0);
  end

  // ------------------------------------------------------ result select
  always_comb begin
    load_out           = 1'b0;
    out_next.kind      = KIND_SAMPLE;
    out_next.left      = smp_l;
    out_next.right     = smp_r;
    out_next.read_data = 16'd0;
    out_next.last      = (smp_k == smp_last);
    if (state == ST_RD_EMIT) begin
      load_out           = slot_free;
      out_next.kind      = KIND_READ;
      out_next.left      = 16'sd0;
      out_next.right     = 16'sd0;
      out_next.read_data = reg_word;
      out_next.last      = 1'b1;
    end else if (state == ST_EMIT) begin
      load_out = slot_free;
    end
  end

  // ---------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      accum  <= '0;
      ph1    <= '0;
      ph2    <= '0;
      phw    <= '0;
      lfsr   <= 15'h7FFF;
      nz_cnt <= '0;
      head_a <= '0;
      head_b <= '0;
      fill_a <= '0;
      fill_b <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd_fire) begin
            unique case (cmd.mode) inside
              MODE_TICK: begin
                accum    <= ACC_W'(tick_total % SAMPLE_CYCLES);
                smp_last <= (tick_due > TOT_W'(MAX_OUT)) ? 2'(MAX_OUT - 1)
                                                          : 2'(tick_due - 1'b1);
                ld_cnt   <= '0;
                if (tick_due != '0) begin
                  state <= ST_LOAD;
                end
              end
              MODE_READ: begin
                state <= ST_RD_EMIT;
              end
              MODE_PUSH_A, MODE_PUSH_B: begin
                push_b    <= (cmd.mode == MODE_PUSH_B);
                push_data <= cmd.write_data;
                push_cnt  <= '0;
                state     <= ST_PUSH;
              end
              default: ;
            endcase
          end
        end
        ST_RD_EMIT: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        ST_PUSH: begin
          if (fa_we) fill_a <= fill_a + 1'b1;
          if (fb_we) fill_b <= fill_b + 1'b1;
          push_cnt <= push_cnt + 1'b1;
          if (push_cnt == 2'd3) begin
            state <= ST_IDLE;
          end
        end
        ST_LOAD: begin
          if (ld_cnt != 4'd0) begin
            shadow[ld_cnt - 1'b1] <= reg_word;
          end
          ld_cnt <= ld_cnt + 1'b1;
          if (ld_cnt == 4'(NUM_SHADOW)) begin
            smp_k <= '0;
            state <= ST_START;
          end
        end
        ST_START: begin
          if (shadow[SH_MIX][7]) begin
            state <= ST_SQ1;
          end else begin
            smp_l <= 16'sd0;
            smp_r <= 16'sd0;
            state <= ST_EMIT;
          end
        end
        ST_SQ1: begin
          if (div_start) begin
            state <= ST_SQ1_W;
          end else begin
            s1    <= 13'sd0;
            state <= ST_SQ2;
          end
        end
        ST_SQ1_W: begin
          if (div_done) begin
            ph1 <= div_rem[12:0];
            s1  <= (div_rem < sq_thr(shadow[SH_SQ1C], tone_p(shadow[SH_SQ1F])))
                   ? chan_vol(shadow[SH_SQ1C]) : -chan_vol(shadow[SH_SQ1C]);
            state <= ST_SQ2;
          end
        end
        ST_SQ2: begin
          if (div_start) begin
            state <= ST_SQ2_W;
          end else begin
            s2    <= 13'sd0;
            state <= ST_WAVE;
          end
        end
        ST_SQ2_W: begin
          if (div_done) begin
            ph2 <= div_rem[12:0];
            s2  <= (div_rem < sq_thr(shadow[SH_SQ2C], tone_p(shadow[SH_SQ2F])))
                   ? chan_vol(shadow[SH_SQ2C]) : -chan_vol(shadow[SH_SQ2C]);
            state <= ST_WAVE;
          end
        end
        ST_WAVE: begin
          if (div_start) begin
            // constant level from the volume code
            case (shadow[SH_WVC][14:13])
              2'd1:    wv <= 13'sd256;
              2'd2:    wv <= 13'sd512;
              2'd3:    wv <= 13'sd1024;
              default: wv <= 13'sd0;
            endcase
            state <= ST_WAVE_W;
          end else begin
            wv    <= 13'sd0;
            state <= ST_NOISE;
          end
        end
        ST_WAVE_W: begin
          if (div_done) begin
            phw   <= div_rem[11:0];
            state <= ST_NOISE;
          end
        end
        ST_NOISE: begin
          if (shadow[SH_NZF][15]) begin
            if (nz_inc >= {1'b0, nz_period}) begin
              nz_cnt <= '0;
              lfsr   <= lfsr_step;
              nz     <= lfsr_step[0] ? chan_vol(shadow[SH_NZC]) : -chan_vol(shadow[SH_NZC]);
            end else begin
              nz_cnt <= nz_inc[21:0];
              nz     <= lfsr[0] ? chan_vol(shadow[SH_NZC]) : -chan_vol(shadow[SH_NZC]);
            end
          end else begin
            nz <= 13'sd0;
          end
          state <= ST_FIFO;
        end
        ST_FIFO: begin
          // scale the tone mix while the FIFO heads are read
          lsc   <= 18'(ladj >>> 3);
          rsc   <= 18'(radj >>> 3);
          pop_a <= (fill_a != '0);
          pop_b <= (fill_b != '0);
          if (fill_a != '0) begin
            head_a <= fifo_wrap((FIFO_CW+1)'(head_a) + 1'b1);
            fill_a <= fill_a - 1'b1;
          end
          if (fill_b != '0) begin
            head_b <= fifo_wrap((FIFO_CW+1)'(head_b) + 1'b1);
            fill_b <= fill_b - 1'b1;
          end
          state <= ST_MIX;
        end
        ST_MIX: begin
          smp_l <= sat16(lfin);
          smp_r <= sat16(rfin);
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            if (smp_k == smp_last) begin
              state <= ST_IDLE;
            end else begin
              smp_k <= smp_k + 1'b1;
              state <= ST_START;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------- assertions
  a_fill_a_bound: assert property (@(posedge clk) disable iff (rst)
    fill_a <= FIFO_CW'(FIFO_DEPTH))
    else $error("FIFO A fill above depth");

  a_fill_b_bound: assert property (@(posedge clk) disable iff (rst)
    fill_b <= FIFO_CW'(FIFO_DEPTH))
    else $error("FIFO B fill above depth");

  a_read_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.kind == KIND_READ)) |-> res.last)
    else $error("read beat without last");

  a_busy_no_cmd: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !cmd_ready)
    else $error("command taken while busy");

endmodule
